### rtl/core/tgarle_pkg.sv
package tgarle_pkg;

    // Decoder phase, one-hot
    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_PIXEL  = 2'b10
    } phase_t;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_BYTES_PER_PIXEL = 1'b0,
        REG_IMAGE_PIXELS    = 1'b1
    } reg_index_t;

    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned RUN_W   = 8;
    localparam int unsigned BPP_W   = 3;

    // Packet header fields
    localparam int unsigned HDR_REPEAT_BIT = 7;
    localparam logic [7:0]  HDR_COUNT_MASK = 8'h7f;

endpackage

### rtl/core/tga_rle_pixel_decoder_unit.sv
// A result appears in the cycle after the byte that completes its pixel is accepted.
// Throughput: one stream byte per cycle, sustained; s_ready drops only while the result
// register holds an untaken result and m_ready is low.
// Reset (aresetn low, synchronous): decoder waits for a packet header, result register
// empty, bytes_per_pixel = 4, image_pixels = 1.
module tga_rle_pixel_decoder_unit
    import tgarle_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata,
    // compressed byte stream
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    // decoded runs
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIXEL_W-1:0] m_pixel_value,
    output logic [RUN_W-1:0]   m_run_length,
    output logic               m_image_done,
    output logic               m_overrun
);

    localparam int BPW   = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int CW    = ((BPW > BPP_W) ? BPW : BPP_W) + 1;
    localparam int IDXW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int NBYTE = (MAX_PIXEL_BYTES < PIXEL_W / 8) ? MAX_PIXEL_BYTES : PIXEL_W / 8;

    // configuration registers
    logic [BPP_W-1:0]   bpp_cfg_reg;
    logic [31:0]        img_cfg_reg;

    // decoder state
    phase_t             phase_reg, phase_next;
    logic [IDXW-1:0]    byte_idx_reg, byte_idx_next;
    logic [RUN_W-1:0]   pkt_left_reg, pkt_left_next;
    logic               repeat_reg, repeat_next;
    logic [PIXEL_W-1:0] asm_reg, asm_next;
    logic [31:0]        img_left_reg, img_left_next;
    logic               ovr_seen_reg, ovr_seen_next;
    logic               fresh_reg, fresh_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_pixel_reg;
    logic [RUN_W-1:0]   m_run_reg;
    logic               m_done_reg;
    logic               m_ovr_reg;

    // combinational results
    logic               accept;
    logic               emit;
    logic [PIXEL_W-1:0] res_pixel;
    logic [RUN_W-1:0]   res_run;
    logic               res_done;
    logic               res_ovr;

    logic [CW-1:0]      eff_bpp;
    logic [CW-1:0]      byte_pos_next;
    logic [PIXEL_W-1:0] asm_new;
    logic [RUN_W-1:0]   hdr_count;
    logic [31:0]        left_base;
    logic               hdr_over;
    logic [31:0]        left_dec;
    logic [31:0]        left_after;
    logic [RUN_W-1:0]   pkt_after;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Clamp bytes per pixel into 1..MAX_PIXEL_BYTES
    always_comb begin
        eff_bpp = CW'(bpp_cfg_reg);
        if (eff_bpp == '0) begin
            eff_bpp = CW'(1);
        end else if (eff_bpp > CW'(MAX_PIXEL_BYTES)) begin
            eff_bpp = CW'(MAX_PIXEL_BYTES);
        end
    end

    // Merge the incoming byte into the pixel under assembly
    always_comb begin
        asm_new = asm_reg;
        for (int i = 0; i < NBYTE; i++) begin
            if (CW'(byte_idx_reg) == CW'(i)) begin
                asm_new[8*i +: 8] = s_in_byte;
            end
        end
        byte_pos_next = CW'(byte_idx_reg) + CW'(1);
    end

    // Header decode: packet size and budget check
    always_comb begin
        hdr_count = RUN_W'(s_in_byte & HDR_COUNT_MASK) + RUN_W'(1);
        left_base = img_left_reg;
        if (fresh_reg) begin
            left_base = (img_cfg_reg == '0) ? 32'd1 : img_cfg_reg;
        end
        hdr_over = {24'd0, hdr_count} > left_base;
    end

    // Pixel completion: budget countdown
    always_comb begin
        left_dec   = repeat_reg ? {24'd0, pkt_left_reg} : 32'd1;
        left_after = img_left_reg - left_dec;
        pkt_after  = '0;
        if (!repeat_reg && pkt_left_reg != '0) begin
            pkt_after = pkt_left_reg - RUN_W'(1);
        end
    end

    // Advance the decoder on each accepted byte
    always_comb begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        pkt_left_next = pkt_left_reg;
        repeat_next   = repeat_reg;
        asm_next      = asm_reg;
        img_left_next = img_left_reg;
        ovr_seen_next = ovr_seen_reg;
        fresh_next    = fresh_reg;
        emit          = 1'b0;
        res_pixel     = asm_new;
        res_run       = repeat_reg ? pkt_left_reg : RUN_W'(1);
        res_done      = 1'b0;
        res_ovr       = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    img_left_next = left_base;
                    fresh_next    = 1'b0;
                    ovr_seen_next = (ovr_seen_reg && !fresh_reg) || hdr_over;
                    repeat_next   = s_in_byte[HDR_REPEAT_BIT];
                    pkt_left_next = (s_in_byte[HDR_REPEAT_BIT] && hdr_over)
                                    ? left_base[RUN_W-1:0] : hdr_count;
                    byte_idx_next = '0;
                    asm_next      = '0;
                    phase_next    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (byte_pos_next < eff_bpp) begin
                        byte_idx_next = IDXW'(byte_pos_next);
                        asm_next      = asm_new;
                    end else begin
                        byte_idx_next = '0;
                        asm_next      = '0;
                        emit          = repeat_reg || (img_left_reg != '0);
                        res_done      = (left_after == '0);
                        res_ovr       = (left_after == '0) && ovr_seen_reg;
                        if (emit) begin
                            img_left_next = left_after;
                        end
                        pkt_left_next = pkt_after;
                        if (pkt_after == '0) begin
                            phase_next = PH_HEADER;
                            if (img_left_next == '0) begin
                                fresh_next    = 1'b1;
                                ovr_seen_next = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // Result register: drop when taken, load on a new result
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_cfg_reg  <= BPP_W'(4);
            img_cfg_reg  <= 32'd1;
            phase_reg    <= PH_HEADER;
            byte_idx_reg <= '0;
            pkt_left_reg <= '0;
            repeat_reg   <= 1'b0;
            asm_reg      <= '0;
            img_left_reg <= 32'd1;
            ovr_seen_reg <= 1'b0;
            fresh_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_BYTES_PER_PIXEL: bpp_cfg_reg <= cfg_wdata[BPP_W-1:0];
                    REG_IMAGE_PIXELS:    img_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            pkt_left_reg <= pkt_left_next;
            repeat_reg   <= repeat_next;
            asm_reg      <= asm_next;
            img_left_reg <= img_left_next;
            ovr_seen_reg <= ovr_seen_next;
            fresh_reg    <= fresh_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_pixel_reg <= res_pixel;
            m_run_reg   <= res_run;
            m_done_reg  <= res_done;
            m_ovr_reg   <= res_ovr;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_reg;
    assign m_run_length  = m_run_reg;
    assign m_image_done  = m_done_reg;
    assign m_overrun     = m_ovr_reg;

endmodule

### rtl/core/tgarle_checker.sv
module tgarle_checker
    import tgarle_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PIXEL_W-1:0] m_pixel_value,
    input logic [RUN_W-1:0]   m_run_length,
    input logic               m_image_done,
    input logic               m_overrun
);

    // Hold a stalled result unchanged
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_value)
            && $stable(m_run_length) && $stable(m_image_done) && $stable(m_overrun))
        else $error("stalled result changed");

    // Run length stays in 1..128
    a_run_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_run_length != '0) && (m_run_length <= RUN_W'(128)))
        else $error("run length out of range");

    // Overrun only on the result that completes the image
    a_overrun_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overrun |-> m_image_done)
        else $error("overrun without image_done");

    // Accept input whenever the result register is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Come out of reset with no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_tgarle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_value (m_pixel_value),
    .m_run_length  (m_run_length),
    .m_image_done  (m_image_done),
    .m_overrun     (m_overrun)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tgarle_pkg::*;

    localparam int unsigned PIX_BYTES_MAX = 4;
    localparam int          DIR_ROWS      = 27;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 160;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          DRAIN_PAUSE   = 4;
    localparam logic [2:0]  PHASE_BPP [PHASES] = '{3'd1, 3'd2, 3'd3, 3'd4,
                                                   3'd0, 3'd7, 3'd5, 3'd6};

    typedef struct packed {
        logic [31:0] pixel;
        logic [7:0]  run_len;
        logic        done;
        logic        overrun;
    } pixel_run_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  bpp;
        logic [31:0] npix;
        logic [7:0]  in_byte;
        logic        typed;
        pixel_run_t  res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    reg_index_t  cfg_index = REG_BYTES_PER_PIXEL;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [PIXEL_W-1:0] m_pixel_value;
    logic [RUN_W-1:0]   m_run_length;
    logic        m_image_done;
    logic        m_overrun;

    // expected run typed into the directed table, travels with its request
    logic        tab_run_valid = 1'b0;
    pixel_run_t  tab_run       = '0;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          items_sent     = 0;
    int          fail_count     = 0;
    int          quiet_cycles   = 0;

    pixel_run_t  runs_due [$];
    stim_row_t   dir_tab [DIR_ROWS];

    // decoder mirror: register copies and packet state
    logic [2:0]  bpp_cfg        = 3'd4;
    logic [31:0] img_pixels_cfg = 32'd1;
    phase_t      dec_phase      = PH_HEADER;
    logic [1:0]  byte_idx       = '0;
    logic [7:0]  pkt_left       = '0;
    logic        pkt_repeat     = 1'b0;
    logic [31:0] pix_acc        = '0;
    logic [31:0] img_left       = 32'd1;
    logic        ovr_seen       = 1'b0;
    logic        img_fresh      = 1'b1;

    tga_rle_pixel_decoder_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .m_run_length  (m_run_length),
        .m_image_done  (m_image_done),
        .m_overrun     (m_overrun)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pixel_bytes(input logic [2:0] bpp);
        if (bpp == 3'd0) return 1;
        if (bpp > PIX_BYTES_MAX) return PIX_BYTES_MAX;
        return 32'(bpp);
    endfunction

    // Advance the decoder mirror by one stream byte; emit marks a run out
    function void decode_byte(input logic [7:0] b, output bit emit, output pixel_run_t run_out);
        logic [7:0]  count;
        logic [31:0] run;
        emit    = 1'b0;
        run_out = '0;
        if (dec_phase == PH_HEADER) begin
            count = {1'b0, b[6:0]} + 8'd1;
            if (img_fresh) begin
                img_left  = (img_pixels_cfg == 32'd0) ? 32'd1 : img_pixels_cfg;
                img_fresh = 1'b0;
                ovr_seen  = 1'b0;
            end
            if (count > img_left) ovr_seen = 1'b1;
            pkt_repeat = b[HDR_REPEAT_BIT];
            if (pkt_repeat && count > img_left) count = img_left[7:0];
            pkt_left  = count;
            byte_idx  = '0;
            pix_acc   = '0;
            dec_phase = PH_PIXEL;
            return;
        end
        pix_acc = pix_acc | (32'(b) << (8 * byte_idx));
        if (int'(byte_idx) + 1 < pixel_bytes(bpp_cfg)) begin
            byte_idx = byte_idx + 2'd1;
            return;
        end
        run_out.pixel = pix_acc;
        byte_idx      = '0;
        pix_acc       = '0;
        if (pkt_repeat) begin
            run = 32'(pkt_left);
            if (run > img_left) run = img_left;
            img_left        = img_left - run;
            pkt_left        = '0;
            run_out.run_len = run[7:0];
            emit            = 1'b1;
        end else begin
            // raw pixels past the image budget are swallowed
            if (img_left > 0) begin
                img_left        = img_left - 32'd1;
                run_out.run_len = 8'd1;
                emit            = 1'b1;
            end
            if (pkt_left > 0) pkt_left = pkt_left - 8'd1;
        end
        run_out.done    = emit && (img_left == 0);
        run_out.overrun = emit && (img_left == 0) && ovr_seen;
        if (pkt_left == 0) begin
            dec_phase = PH_HEADER;
            if (img_left == 0) begin
                img_fresh = 1'b1;
                ovr_seen  = 1'b0;
            end
        end
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] b);
        stim_row_t row;
        row         = '0;
        row.in_byte = b;
        return row;
    endfunction

    function automatic stim_row_t check_row(input logic [7:0] b, input logic [31:0] pix,
                                            input logic [7:0] run, input logic done,
                                            input logic ovr);
        stim_row_t row;
        row       = byte_row(b);
        row.typed = 1'b1;
        row.res   = '{pix, run, done, ovr};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] bpp, input logic [31:0] npix);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.bpp    = bpp;
        row.npix   = npix;
        return row;
    endfunction

    // Drive one byte request and hold it until accepted; returns at a falling edge
    task automatic push_byte(input logic [7:0] b, input bit typed, input pixel_run_t res);
        int gap;
        gap = 0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        tab_run_valid <= typed;
        tab_run       <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drop the request line and wait until every expected run has come out
    task automatic drain_runs();
        s_valid <= 1'b0;
        while (runs_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    // Write both registers; junk in the unused upper bits of bytes_per_pixel
    task automatic configure(input logic [2:0] bpp, input logic [31:0] npix);
        logic [31:0] data;
        data      = $urandom();
        data[2:0] = bpp;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BYTES_PER_PIXEL;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_index <= REG_IMAGE_PIXELS;
        cfg_wdata <= npix;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One packet with random content; sometimes a stray byte or a cut-short packet
    task automatic send_packet();
        int   roll;
        int   count;
        int   nbytes;
        logic rep;
        roll = $urandom_range(99);
        if (roll < 8) begin
            push_byte(8'($urandom_range(255)), 1'b0, '0);
            return;
        end
        rep  = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 70) count = $urandom_range(7, 0);
        else if (roll < 97) count = $urandom_range(40, 8);
        else count = $urandom_range(127, 41);
        nbytes = rep ? pixel_bytes(bpp_cfg) : (count + 1) * pixel_bytes(bpp_cfg);
        if ($urandom_range(99) < 5) nbytes = $urandom_range(nbytes - 1, 0);
        push_byte({rep, 7'(count)}, 1'b0, '0);
        repeat (nbytes) push_byte(8'($urandom_range(255)), 1'b0, '0);
    endtask

    // Result side: stall at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check finished runs, track accepted bytes and register writes
    always @(posedge aclk) begin
        pixel_run_t got;
        pixel_run_t want;
        pixel_run_t pred;
        bit         emit;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_pixel_value, m_run_length, m_image_done, m_overrun};
                if (runs_due.size() == 0) begin
                    $error("unexpected run: pixel_value %h run_length %0d",
                           got.pixel, got.run_len);
                    fail_count++;
                end else begin
                    want = runs_due.pop_front();
                    if (got.pixel !== want.pixel) begin
                        $error("pixel_value: expected %h, got %h", want.pixel, got.pixel);
                        fail_count++;
                    end
                    if (got.run_len !== want.run_len) begin
                        $error("run_length: expected %0d, got %0d", want.run_len, got.run_len);
                        fail_count++;
                    end
                    if (got.done !== want.done) begin
                        $error("image_done: expected %b, got %b", want.done, got.done);
                        fail_count++;
                    end
                    if (got.overrun !== want.overrun) begin
                        $error("overrun: expected %b, got %b", want.overrun, got.overrun);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, emit, pred);
                if (tab_run_valid) runs_due.push_back(tab_run);
                else if (emit) runs_due.push_back(pred);
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_BYTES_PER_PIXEL) bpp_cfg = cfg_wdata[BPP_W-1:0];
                else img_pixels_cfg = cfg_wdata;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[tga_rle_pixel_decoder_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          start;
        logic [31:0] npix;

        dir_tab = '{
            // reset registers: four bytes per pixel, one-pixel image
            byte_row(8'h80), byte_row(8'h01), byte_row(8'h02), byte_row(8'h03),
            check_row(8'h04, 32'h0403_0201, 8'd1, 1'b1, 1'b0),
            // zero bytes per pixel and zero image size both count as one
            cfg_row(3'd0, 32'd0),
            byte_row(8'h01),
            check_row(8'hff, 32'h0000_00ff, 8'd1, 1'b1, 1'b1),
            byte_row(8'h00),
            byte_row(8'hff),
            check_row(8'h00, 32'h0000_0000, 8'd1, 1'b1, 1'b1),
            // bytes per pixel clamped to four; longest repeat, then exact finish
            cfg_row(3'd7, 32'd130),
            byte_row(8'hff), byte_row(8'h12), byte_row(8'h34), byte_row(8'h56),
            check_row(8'h78, 32'h7856_3412, 8'd128, 1'b0, 1'b0),
            byte_row(8'h81), byte_row(8'hef), byte_row(8'hbe), byte_row(8'had),
            check_row(8'hde, 32'hdead_beef, 8'd2, 1'b1, 1'b0),
            // three-byte pixels, upper byte zero
            cfg_row(3'd3, 32'd2),
            byte_row(8'h00), byte_row(8'hab), byte_row(8'hcd),
            check_row(8'hef, 32'h00ef_cdab, 8'd1, 1'b0, 1'b0)
        };

        // hold reset, then release at a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].is_cfg) begin
                drain_runs();
                configure(dir_tab[i].bpp, dir_tab[i].npix);
            end else begin
                push_byte(dir_tab[i].in_byte, dir_tab[i].typed, dir_tab[i].res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_runs();
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            case (p)
                0: npix = 32'd1;
                1: npix = $urandom_range(40, 1);
                2: npix = $urandom_range(400, 1);
                3: npix = 32'd0;
                4: npix = $urandom_range(20, 1);
                5: npix = $urandom_range(3000, 100);
                6: npix = $urandom_range(60, 1);
                default: npix = 32'hffff_ffff;
            endcase
            configure(PHASE_BPP[p], npix);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_packet();
        end

        drain_runs();
        if (fail_count == 0) begin
            $display("[tga_rle_pixel_decoder_unit] OK");
        end else begin
            $display("[tga_rle_pixel_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule
